FILE: src/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    // Item modes
    localparam logic [1:0] MODE_CPU_WR  = 2'd0;
    localparam logic [1:0] MODE_PPU     = 2'd1;
    localparam logic [1:0] MODE_CPU_RD  = 2'd2;

    // Bank register decode: address bits 15:12
    localparam logic [3:0] HI_PRG0      = 4'h8;
    localparam logic [3:0] HI_MIRROR    = 4'h9;
    localparam logic [3:0] HI_PRG1      = 4'hA;
    localparam logic [3:0] HI_CHR_FIRST = 4'hB;
    localparam logic [3:0] HI_CHR_LAST  = 4'hE;

    // Control decode: address & 0xC00C
    localparam logic [15:0] CTL_SEL_MASK  = 16'hC00C;
    localparam logic [15:0] CTL_SINGLE    = 16'h8004;
    localparam logic [15:0] CTL_IRQ_SET   = 16'h800C;
    localparam logic [15:0] CTL_IRQ_ACK   = 16'hC004;
    localparam logic [15:0] CTL_CNT_EN    = 16'hC008;
    localparam logic [15:0] CTL_CNT_CLEAR = 16'hC00C;

    // Terminal value of the A13 counter; reaching it raises an interrupt and restarts the count
    localparam logic [6:0] IRQ_PERIOD = 7'd84;

    localparam logic [7:0] PRG_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    // Mapper state as seen after the current beat
    typedef struct packed {
        logic [7:0]      prg_bank0;
        logic [7:0]      prg_bank1;
        logic [7:0][7:0] chr_banks;
        logic            mirror_bit;
        logic [1:0]      single_screen;
        logic            irq_pending;
    } t_map_state;

    typedef struct packed {
        logic       irq_line;
        logic [1:0] mirroring;
        logic [7:0] bank;
        logic       bank_valid;
    } t_result;

endpackage

FILE: src/cbm_state.sv
// Mapper registers, write decode and A13 interrupt counter.
module cbm_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cbm_pkg::t_item      i_item,
    output cbm_pkg::t_map_state o_next
);

    logic [7:0]      r_prg0, n_prg0;
    logic [7:0]      r_prg1, n_prg1;
    logic [7:0][7:0] r_chr, n_chr;
    logic            r_mirror, n_mirror;
    logic [1:0]      r_single, n_single;
    logic            r_prev_a13, n_prev_a13;
    logic [6:0]      r_count, n_count;
    logic            r_cnt_en, n_cnt_en;
    logic            r_irq, n_irq;

    logic [3:0]  hi;
    logic [3:0]  hoff;
    logic [2:0]  chr_idx;
    logic [15:0] ctl;
    logic [6:0]  count_inc;
    logic        a13;

    always_comb begin
        hi        = i_item.address[15:12];
        hoff      = hi - cbm_pkg::HI_CHR_FIRST;
        chr_idx   = {hoff[1:0], i_item.address[1]};
        ctl       = i_item.address & cbm_pkg::CTL_SEL_MASK;
        count_inc = r_count + 7'd1;
        a13       = i_item.address[13];

        n_prg0     = r_prg0;
        n_prg1     = r_prg1;
        n_chr      = r_chr;
        n_mirror   = r_mirror;
        n_single   = r_single;
        n_prev_a13 = r_prev_a13;
        n_count    = r_count;
        n_cnt_en   = r_cnt_en;
        n_irq      = r_irq;

        case (i_item.mode)
            cbm_pkg::MODE_CPU_WR: begin
                if (hi == cbm_pkg::HI_PRG0) begin
                    n_prg0 = i_item.data;
                end else if (hi == cbm_pkg::HI_MIRROR) begin
                    n_mirror = i_item.data[0];
                end else if (hi == cbm_pkg::HI_PRG1) begin
                    n_prg1 = i_item.data;
                end else if (hi >= cbm_pkg::HI_CHR_FIRST && hi <= cbm_pkg::HI_CHR_LAST) begin
                    if (i_item.address[0]) begin
                        n_chr[chr_idx][7:4] = i_item.data[3:0];
                    end else begin
                        n_chr[chr_idx][3:0] = i_item.data[3:0];
                    end
                end

                case (ctl)
                    cbm_pkg::CTL_SINGLE:    n_single = i_item.data[1:0];
                    cbm_pkg::CTL_IRQ_SET:   n_irq = 1'b1;
                    cbm_pkg::CTL_IRQ_ACK:   n_irq = 1'b0;
                    cbm_pkg::CTL_CNT_EN:    n_cnt_en = 1'b1;
                    cbm_pkg::CTL_CNT_CLEAR: begin
                        n_cnt_en = 1'b0;
                        n_count  = '0;
                        n_irq    = 1'b0;
                    end
                    default: ;
                endcase
            end
            cbm_pkg::MODE_PPU: begin
                // advance the counter on each high-to-low transition of A13 while enabled
                if (r_prev_a13 && !a13 && r_cnt_en) begin
                    if (count_inc == cbm_pkg::IRQ_PERIOD) begin
                        n_count = '0;
                        n_irq   = 1'b1;
                    end else begin
                        n_count = count_inc;
                    end
                end
                n_prev_a13 = a13;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg0     <= '0;
            r_prg1     <= '0;
            r_chr      <= '0;
            r_mirror   <= 1'b0;
            r_single   <= '0;
            r_prev_a13 <= 1'b0;
            r_count    <= '0;
            r_cnt_en   <= 1'b0;
            r_irq      <= 1'b0;
        end else if (i_fire) begin
            r_prg0     <= n_prg0;
            r_prg1     <= n_prg1;
            r_chr      <= n_chr;
            r_mirror   <= n_mirror;
            r_single   <= n_single;
            r_prev_a13 <= n_prev_a13;
            r_count    <= n_count;
            r_cnt_en   <= n_cnt_en;
            r_irq      <= n_irq;
        end
    end

    assign o_next.prg_bank0     = n_prg0;
    assign o_next.prg_bank1     = n_prg1;
    assign o_next.chr_banks     = n_chr;
    assign o_next.mirror_bit    = n_mirror;
    assign o_next.single_screen = n_single;
    assign o_next.irq_pending   = n_irq;

endmodule

FILE: src/cbm_lookup.sv
// Bank lookup and mirroring select for one beat.
module cbm_lookup (
    input  cbm_pkg::t_item      i_item,
    input  cbm_pkg::t_map_state i_state,
    input  logic [7:0]          i_prg_mask,
    output cbm_pkg::t_result    o_result
);

    logic [7:0] prg_bank;
    logic [7:0] mask_m1;

    always_comb begin
        mask_m1 = i_prg_mask - 8'd1;
        case (i_item.address[14:13])
            2'd0:    prg_bank = i_state.prg_bank0 & i_prg_mask;
            2'd1:    prg_bank = i_state.prg_bank1 & i_prg_mask;
            2'd2:    prg_bank = mask_m1 & i_prg_mask;
            default: prg_bank = i_prg_mask;
        endcase

        o_result.irq_line   = i_state.irq_pending;
        o_result.mirroring  = (i_state.single_screen[1]) ? i_state.single_screen
                                                         : {1'b0, i_state.mirror_bit};
        o_result.bank       = '0;
        o_result.bank_valid = 1'b0;

        case (i_item.mode)
            cbm_pkg::MODE_CPU_WR, cbm_pkg::MODE_CPU_RD: begin
                if (i_item.address[15]) begin
                    o_result.bank       = prg_bank;
                    o_result.bank_valid = 1'b1;
                end
            end
            cbm_pkg::MODE_PPU: begin
                if (!i_item.address[13]) begin
                    o_result.bank       = i_state.chr_banks[i_item.address[12:10]];
                    o_result.bank_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: src/cartridge_bank_mapper_with_a13_irq_unit.sv
// Top level of the cartridge bank mapper with A13 interrupt counter.
//
// One beat in, one beat out. Each input beat is a CPU write (mode 0), a PPU
// address sample (mode 1) or a CPU read lookup (mode 2); mode 3 changes nothing
// and returns bank 0, not valid. A beat lands in an input register, passes
// combinationally through the write decode, the A13 counter and the bank lookup,
// and its result lands in an output register, where it stays until taken.
// Mapper state updates at the same edge the result is captured, so the next
// beat already sees it. A result is valid once the output register holds it,
// and a beat waits in the input register while an untaken result blocks it.
// Throughput is one beat per cycle, limited only by results being taken. Results
// report state after the beat: a write shows the PRG bank at the written
// address with the new bank registers in place. The PRG mask register is
// written through the config channel, which is always ready; write it only
// while no beat is in flight.
module cartridge_bank_mapper_with_a13_irq_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,

    // input beats
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0] i_data,

    // result beats
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_irq_line,
    output logic [1:0] o_mirroring,
    output logic [7:0] o_bank,
    output logic       o_bank_valid
);

    logic                r_in_valid;
    cbm_pkg::t_item      r_in;
    logic                r_out_valid;
    cbm_pkg::t_result    r_out;
    logic [7:0]          r_prg_mask;

    logic                advance;
    logic                fire;
    logic                in_accept;
    cbm_pkg::t_map_state next_state;
    cbm_pkg::t_result    result;

    // Output stage drains or is empty: the input stage may move forward.
    assign advance     = !r_out_valid || i_ready;
    assign fire        = r_in_valid && advance;
    assign o_ready     = !r_in_valid || advance;
    assign in_accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= cbm_pkg::PRG_MASK_RESET;
        end else if (i_cfg_valid) begin
            r_prg_mask <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.mode    <= i_mode;
            r_in.address <= i_address;
            r_in.data    <= i_data;
        end
    end

    cbm_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_next  (next_state)
    );

    cbm_lookup u_lookup (
        .i_item     (r_in),
        .i_state    (next_state),
        .i_prg_mask (r_prg_mask),
        .o_result   (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_irq_line   = r_out.irq_line;
    assign o_mirroring  = r_out.mirroring;
    assign o_bank       = r_out.bank;
    assign o_bank_valid = r_out.bank_valid;

endmodule
